>>> hdl/qmn_pkg.sv
// Shared constants for the normalised quaternion product core.
package qmn_pkg;

    localparam int NUM_COMP = 4;

    // component order within a quaternion
    localparam int CW = 0;
    localparam int CX = 1;
    localparam int CY = 2;
    localparam int CZ = 3;

endpackage

>>> hdl/qmn_hamilton.sv
// Hamilton product s * f: registered partial products, then registered sums.
module qmn_hamilton #(
    parameter int CB   = 16,
    parameter int PRE  = 0,
    parameter int PW   = 32,
    parameter int SUMW = 34
) (
    input  logic                   i_clk,
    input  logic signed [CB-1:0]   i_f [qmn_pkg::NUM_COMP],
    input  logic signed [CB-1:0]   i_s [qmn_pkg::NUM_COMP],
    output logic signed [SUMW-1:0] o_p [qmn_pkg::NUM_COMP]
);
    import qmn_pkg::*;

    // r_prod[i][j] = s_i * f_j, floored by PRE bits
    logic signed [PW-1:0] r_prod [NUM_COMP][NUM_COMP];

    genvar gi, gj;
    generate
        for (gi = 0; gi < NUM_COMP; gi++) begin : g_row
            for (gj = 0; gj < NUM_COMP; gj++) begin : g_col
                logic signed [2*CB-1:0] full;
                logic signed [2*CB-1:0] shifted;
                assign full    = i_s[gi] * i_f[gj];
                assign shifted = full >>> PRE;
                always_ff @(posedge i_clk) begin
                    r_prod[gi][gj] <= shifted[PW-1:0];
                end
            end
        end
    endgenerate

    function automatic logic signed [SUMW-1:0] ext(input logic signed [PW-1:0] v);
        ext = SUMW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        o_p[CW] <= ext(r_prod[CW][CW]) - ext(r_prod[CX][CX])
                 - ext(r_prod[CY][CY]) - ext(r_prod[CZ][CZ]);
        o_p[CX] <= ext(r_prod[CW][CX]) + ext(r_prod[CX][CW])
                 + ext(r_prod[CY][CZ]) - ext(r_prod[CZ][CY]);
        o_p[CY] <= ext(r_prod[CW][CY]) - ext(r_prod[CX][CZ])
                 + ext(r_prod[CY][CW]) + ext(r_prod[CZ][CX]);
        o_p[CZ] <= ext(r_prod[CW][CZ]) + ext(r_prod[CX][CY])
                 - ext(r_prod[CY][CX]) + ext(r_prod[CZ][CW]);
    end

endmodule

>>> hdl/qmn_norm.sv
// Magnitudes, block scaling to 31 bits, squares and sum of squares.
module qmn_norm #(
    parameter int SUMW = 34,
    parameter int MPW  = 31,
    parameter int SW   = 64
) (
    input  logic                   i_clk,
    input  logic signed [SUMW-1:0] i_p   [qmn_pkg::NUM_COMP],
    output logic [2*MPW-1:0]       o_sq  [qmn_pkg::NUM_COMP],
    output logic                   o_neg [qmn_pkg::NUM_COMP],
    output logic [SW-1:0]          o_sum
);
    import qmn_pkg::*;

    localparam int SHW = $clog2(SUMW + 1);

    logic [SUMW-1:0]  r_mag   [NUM_COMP];
    logic             r_neg_a [NUM_COMP];
    logic [SUMW-1:0]  r_all;
    logic [MPW-1:0]   r_mp    [NUM_COMP];
    logic             r_neg_b [NUM_COMP];
    logic [2*MPW-1:0] r_sq    [NUM_COMP];
    logic             r_neg_c [NUM_COMP];
    logic [SHW-1:0]   len;
    logic [SHW-1:0]   shamt;
    logic [SUMW-1:0]  all_c;

    always_comb begin
        all_c = '0;
        for (int i = 0; i < NUM_COMP; i++) begin
            all_c = all_c | (i_p[i][SUMW-1] ? SUMW'(-i_p[i]) : SUMW'(i_p[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_COMP; i++) begin
            r_mag[i]   <= i_p[i][SUMW-1] ? SUMW'(-i_p[i]) : SUMW'(i_p[i]);
            r_neg_a[i] <= i_p[i][SUMW-1];
        end
        r_all <= all_c;
    end

    // bit length of the OR of all magnitudes
    always_comb begin
        len = '0;
        for (int k = 0; k < SUMW; k++) begin
            if (r_all[k]) len = SHW'(k + 1);
        end
        shamt = (len > SHW'(31)) ? SHW'(len - SHW'(31)) : '0;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_COMP; i++) begin
            r_mp[i]    <= MPW'(r_mag[i] >> shamt);
            r_neg_b[i] <= r_neg_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_COMP; i++) begin
            r_sq[i]    <= (2*MPW)'(r_mp[i]) * (2*MPW)'(r_mp[i]);
            r_neg_c[i] <= r_neg_b[i];
        end
    end

    // squares go out alongside their sum
    always_ff @(posedge i_clk) begin
        o_sum <= SW'(r_sq[CW]) + SW'(r_sq[CX]) + SW'(r_sq[CY]) + SW'(r_sq[CZ]);
        for (int i = 0; i < NUM_COMP; i++) begin
            o_sq[i]  <= r_sq[i];
            o_neg[i] <= r_neg_c[i];
        end
    end

endmodule

>>> hdl/qmn_lane.sv
// One component lane: bit-serial-pipelined search for round(2^FB * m / sqrt(S)).
module qmn_lane #(
    parameter int FB = 14,
    parameter int SW = 64,
    parameter int QW = 62
) (
    input  logic          i_clk,
    input  logic [SW-1:0] i_sum_sq,
    input  logic [QW-1:0] i_sq,
    input  logic          i_neg,
    output logic [FB:0]   o_mag,
    output logic          o_neg
);
    localparam int AW = SW + 2*FB + 5;
    localparam int NS = FB + 1;

    // per stage: c, d^2*S and d*S with d = 2c-1, S, target, sign
    logic [FB:0]          r_c   [NS];
    logic signed [AW-1:0] r_d2  [NS];
    logic signed [AW-1:0] r_ds  [NS];
    logic signed [AW-1:0] r_s   [NS];
    logic signed [AW-1:0] r_t   [NS];
    logic                 r_neg [NS];

    genvar gj;
    generate
        for (gj = 0; gj < NS; gj++) begin : g_stage
            localparam int K = FB - gj;
            logic [FB:0]          c_in;
            logic signed [AW-1:0] d2_in, ds_in, s_in, t_in, cand;
            logic                 neg_in, ok;

            if (gj == 0) begin : g_first
                assign s_in   = $signed({{(AW-SW){1'b0}}, i_sum_sq});
                assign t_in   = $signed({{(AW-QW){1'b0}}, i_sq}) <<< (2*FB + 2);
                assign d2_in  = s_in;
                assign ds_in  = -s_in;
                assign c_in   = '0;
                assign neg_in = i_neg;
            end else begin : g_next
                assign s_in   = r_s[gj-1];
                assign t_in   = r_t[gj-1];
                assign d2_in  = r_d2[gj-1];
                assign ds_in  = r_ds[gj-1];
                assign c_in   = r_c[gj-1];
                assign neg_in = r_neg[gj-1];
            end

            // (d + 2^(K+1))^2 S = d^2 S + d S 2^(K+2) + S 2^(2K+2)
            assign cand = d2_in + (ds_in <<< (K + 2)) + (s_in <<< (2*K + 2));
            assign ok   = !c_in[FB] && (cand <= t_in);

            always_ff @(posedge i_clk) begin
                r_c[gj]   <= ok ? (c_in | ((FB+1)'(1) << K)) : c_in;
                r_d2[gj]  <= ok ? cand : d2_in;
                r_ds[gj]  <= ok ? (ds_in + (s_in <<< (K + 1))) : ds_in;
                r_s[gj]   <= s_in;
                r_t[gj]   <= t_in;
                r_neg[gj] <= neg_in;
            end
        end
    endgenerate

    assign o_mag = r_c[NS-1];
    assign o_neg = r_neg[NS-1];

endmodule

>>> hdl/quaternion_multiply_normalize_core.sv
// Top level: normalised Hamilton quaternion product, four component lanes and merge.
//
// Usage: drive the eight input components (first and second quaternion, signed
// fixed point with FRACTION_BITS fractional bits) and pulse start for one beat.
// busy is held low, so a new beat may be offered on every clock cycle.
// The result is second * first scaled to unit length, rounded to nearest,
// saturated to the component range; zero_norm flags a zero product, whose
// components are then all zero.
// Registers from the start beat to the o_valid strobe: the partial products and
// sums of the product; magnitude, scaling, squares and sum of squares; the
// quotient bit stages of each lane; the merge register. Throughput: one beat per cycle,
// set by the fully pipelined lanes.
// Each result is on the o_prod_* ports for exactly one cycle with o_valid high;
// the receiver cannot stall, so it must take every result as it appears.
// Reset (synchronous, active low) clears the valid pipeline only; no item in
// flight survives it.
module quaternion_multiply_normalize_core #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COMPONENT_BITS-1:0] i_first_w,
    input  logic signed [COMPONENT_BITS-1:0] i_first_x,
    input  logic signed [COMPONENT_BITS-1:0] i_first_y,
    input  logic signed [COMPONENT_BITS-1:0] i_first_z,
    input  logic signed [COMPONENT_BITS-1:0] i_second_w,
    input  logic signed [COMPONENT_BITS-1:0] i_second_x,
    input  logic signed [COMPONENT_BITS-1:0] i_second_y,
    input  logic signed [COMPONENT_BITS-1:0] i_second_z,
    output logic                             o_valid,
    output logic signed [COMPONENT_BITS-1:0] o_prod_w,
    output logic signed [COMPONENT_BITS-1:0] o_prod_x,
    output logic signed [COMPONENT_BITS-1:0] o_prod_y,
    output logic signed [COMPONENT_BITS-1:0] o_prod_z,
    output logic                             o_zero_norm
);
    import qmn_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int FB   = FRACTION_BITS;
    // products are floored so the Hamilton sums stay within 64 bits
    localparam int PRE  = (2*CB > 62) ? (2*CB - 62) : 0;
    localparam int PW   = 2*CB - PRE;
    localparam int SUMW = PW + 2;
    localparam int MPW  = (SUMW < 31) ? SUMW : 31;
    localparam int SW   = 2*MPW + 2;
    localparam int LAT  = FB + 8;
    localparam int ZD   = FB + 1;
    // signed width that holds +-2^FB and the saturation limits
    localparam int VW   = ((FB + 2 > CB) ? (FB + 2) : CB) + 1;

    logic signed [CB-1:0]   f_in   [NUM_COMP];
    logic signed [CB-1:0]   s_in   [NUM_COMP];
    logic signed [SUMW-1:0] ham_p  [NUM_COMP];
    logic [2*MPW-1:0]       nrm_sq [NUM_COMP];
    logic                   nrm_neg[NUM_COMP];
    logic [SW-1:0]          nrm_sum;
    logic [FB:0]            ln_mag [NUM_COMP];
    logic                   ln_neg [NUM_COMP];
    logic signed [CB-1:0]   sat    [NUM_COMP];

    logic [LAT-2:0] r_vld;
    logic [ZD-1:0]  r_zero;

    assign busy = 1'b0;

    assign f_in[CW] = i_first_w;
    assign f_in[CX] = i_first_x;
    assign f_in[CY] = i_first_y;
    assign f_in[CZ] = i_first_z;
    assign s_in[CW] = i_second_w;
    assign s_in[CX] = i_second_x;
    assign s_in[CY] = i_second_y;
    assign s_in[CZ] = i_second_z;

    qmn_hamilton #(.CB(CB), .PRE(PRE), .PW(PW), .SUMW(SUMW)) u_ham (
        .i_clk (i_clk),
        .i_f   (f_in),
        .i_s   (s_in),
        .o_p   (ham_p)
    );

    qmn_norm #(.SUMW(SUMW), .MPW(MPW), .SW(SW)) u_norm (
        .i_clk (i_clk),
        .i_p   (ham_p),
        .o_sq  (nrm_sq),
        .o_neg (nrm_neg),
        .o_sum (nrm_sum)
    );

    // one quotient lane per component
    genvar gl;
    generate
        for (gl = 0; gl < NUM_COMP; gl++) begin : g_lane
            qmn_lane #(.FB(FB), .SW(SW), .QW(2*MPW)) u_lane (
                .i_clk    (i_clk),
                .i_sum_sq (nrm_sum),
                .i_sq     (nrm_sq[gl]),
                .i_neg    (nrm_neg[gl]),
                .o_mag    (ln_mag[gl]),
                .o_neg    (ln_neg[gl])
            );
        end
    endgenerate

    // merge: apply sign, saturate to the component range
    always_comb begin
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] vmax;
        logic signed [VW-1:0] vmin;
        vmax = VW'((64'sd1 <<< (CB - 1)) - 64'sd1);
        vmin = -vmax - VW'(1);
        for (int i = 0; i < NUM_COMP; i++) begin
            v = $signed({{(VW-FB-1){1'b0}}, ln_mag[i]});
            if (ln_neg[i]) v = -v;
            if (v > vmax) v = vmax;
            if (v < vmin) v = vmin;
            sat[i] = v[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[LAT-3:0], start & ~busy};
            o_valid <= r_vld[LAT-2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero      <= {r_zero[ZD-2:0], (nrm_sum == '0)};
        o_zero_norm <= r_zero[ZD-1];
        o_prod_w    <= r_zero[ZD-1] ? '0 : sat[CW];
        o_prod_x    <= r_zero[ZD-1] ? '0 : sat[CX];
        o_prod_y    <= r_zero[ZD-1] ? '0 : sat[CY];
        o_prod_z    <= r_zero[ZD-1] ? '0 : sat[CZ];
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the normalised quaternion product core: directed and random beats, self-checked.
module tb_top;
    import qmn_pkg::*;

    localparam int CB      = 16;
    localparam int FB      = 14;
    localparam int LATENCY = FB + 8;

    typedef logic signed [CB-1:0] comp_t;

    typedef struct {
        comp_t fst [NUM_COMP];
        comp_t snd [NUM_COMP];
    } quat_pair_t;

    typedef struct {
        comp_t unit [NUM_COMP];
        logic  zero;
    } unit_quat_t;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    comp_t i_first_w = '0, i_first_x = '0, i_first_y = '0, i_first_z = '0;
    comp_t i_second_w = '0, i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic  o_valid;
    comp_t o_prod_w, o_prod_x, o_prod_y, o_prod_z;
    logic  o_zero_norm;

    unit_quat_t pending_units[$];
    int         n_fail = 0;

    quaternion_multiply_normalize_core #(
        .COMPONENT_BITS(CB),
        .FRACTION_BITS (FB)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_first_w  (i_first_w),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_w (i_second_w),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .o_valid    (o_valid),
        .o_prod_w   (o_prod_w),
        .o_prod_x   (o_prod_x),
        .o_prod_y   (o_prod_y),
        .o_prod_z   (o_prod_z),
        .o_zero_norm(o_zero_norm)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact normalised Hamilton product, second (left) times first.
    function automatic unit_quat_t normalise_product(quat_pair_t q);
        longint          p [NUM_COMP];
        longint unsigned m [NUM_COMP];
        longint unsigned all_bits, sumsq;
        logic [127:0]    rhs, lhs, twox, d;
        longint          lo, hi, mid, v;
        int              sh;
        longint          fw, fx, fy, fz, sw, sx, sy, sz;
        unit_quat_t      r;
        fw = q.fst[CW]; fx = q.fst[CX]; fy = q.fst[CY]; fz = q.fst[CZ];
        sw = q.snd[CW]; sx = q.snd[CX]; sy = q.snd[CY]; sz = q.snd[CZ];
        p[CW] = sw*fw - sx*fx - sy*fy - sz*fz;
        p[CX] = sw*fx + sx*fw + sy*fz - sz*fy;
        p[CY] = sw*fy - sx*fz + sy*fw + sz*fx;
        p[CZ] = sw*fz + sx*fy - sy*fx + sz*fw;
        all_bits = 0;
        for (int i = 0; i < NUM_COMP; i++) begin
            m[i] = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
            all_bits |= m[i];
        end
        // block scaling: shift until every magnitude fits in 31 bits
        sh = 0;
        while ((all_bits >> sh) >> 31 != 0) sh++;
        sumsq = 0;
        for (int i = 0; i < NUM_COMP; i++) begin
            m[i] = m[i] >> sh;
            sumsq += m[i] * m[i];
        end
        r.zero = (sumsq == 0);
        for (int i = 0; i < NUM_COMP; i++) begin
            if (r.zero) begin
                r.unit[i] = '0;
            end else begin
                // largest n with (2n-1)^2 * S <= (2 * 2^FB * m)^2, ties away from zero
                twox = 128'(m[i]) << (FB + 1);
                rhs  = twox * twox;
                lo   = 0;
                hi   = longint'(1) << FB;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 1) / 2;
                    d   = 128'(2 * mid - 1);
                    lhs = d * d * 128'(sumsq);
                    if (lhs <= rhs) lo = mid;
                    else            hi = mid - 1;
                end
                v = (p[i] < 0) ? -lo : lo;
                if (v > 32767)  v = 32767;
                if (v < -32768) v = -32768;
                r.unit[i] = comp_t'(v);
            end
        end
        return r;
    endfunction

    // Offer one beat from the falling edge; returns at the accepting edge.
    task automatic send_beat(quat_pair_t q);
        @(negedge i_clk);
        i_first_w  = q.fst[CW]; i_first_x  = q.fst[CX];
        i_first_y  = q.fst[CY]; i_first_z  = q.fst[CZ];
        i_second_w = q.snd[CW]; i_second_x = q.snd[CX];
        i_second_y = q.snd[CY]; i_second_z = q.snd[CZ];
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_units.push_back(normalise_product(q));
    endtask

    task automatic idle_gap(int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
    endtask

    function automatic quat_pair_t make_pair(comp_t a[NUM_COMP], comp_t b[NUM_COMP]);
        quat_pair_t q;
        q.fst = a;
        q.snd = b;
        return q;
    endfunction

    function automatic comp_t random_comp(int mode);
        case (mode)
            0:       return comp_t'($urandom);
            1:       return comp_t'($urandom_range(0, 64)) - comp_t'(32);
            2:       return $urandom_range(0, 1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
            3:       return comp_t'($urandom_range(0, 32768)) - comp_t'(16384);
            default: return '0;
        endcase
    endfunction

    function automatic quat_pair_t random_pair();
        quat_pair_t q;
        int         mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < NUM_COMP; i++) begin
            // mostly full-range; some tiny, extreme, near-unit or sparse lanes
            q.fst[i] = random_comp(mode < 5 ? 0 : mode - 4);
            q.snd[i] = random_comp(mode < 5 ? 0 : $urandom_range(0, 4));
        end
        // occasionally an all-zero factor, so the zero-norm flag fires
        if ($urandom_range(0, 40) == 0) q.fst = '{default: '0};
        if ($urandom_range(0, 40) == 0) q.snd = '{default: '0};
        return q;
    endfunction

    // Edge cases: zero factors, identity, saturated extremes, axis units.
    task automatic test_directed();
        comp_t z[NUM_COMP], one[NUM_COMP], mx[NUM_COMP], mn[NUM_COMP];
        comp_t ax[NUM_COMP], mixd[NUM_COMP], tiny[NUM_COMP];
        z    = '{default: '0};
        one  = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        mx   = '{default: 16'sh7fff};
        mn   = '{default: 16'sh8000};
        ax   = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        mixd = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        tiny = '{16'sd0, 16'sd0, 16'sd0, 16'sd1};
        send_beat(make_pair(z, z));
        send_beat(make_pair(z, mx));
        send_beat(make_pair(mn, z));
        send_beat(make_pair(one, one));
        send_beat(make_pair(mx, mx));
        send_beat(make_pair(mn, mn));
        send_beat(make_pair(mx, mn));
        send_beat(make_pair(mixd, mixd));
        send_beat(make_pair(mixd, mn));
        send_beat(make_pair(ax, ax));
        send_beat(make_pair(ax, one));
        send_beat(make_pair(one, ax));
        send_beat(make_pair(tiny, tiny));
        send_beat(make_pair(tiny, mn));
        send_beat(make_pair('{16'sd3, 16'sd0, 16'sd0, 16'sd4}, one));
        send_beat(make_pair('{16'sd1, 16'sd1, 16'sd0, 16'sd0}, '{16'sd1, 16'sd0, 16'sd0, 16'sd0}));
        send_beat(make_pair('{16'sd1, -16'sd1, 16'sd1, -16'sd1}, tiny));
        idle_gap(1);
    endtask

    task automatic test_random(int n, bit with_idle);
        repeat (n) begin
            send_beat(random_pair());
            maybe_idle(with_idle);
        end
    endtask

    // Sender holds off until the pipe has drained, then restarts back to back.
    task automatic test_drain_pause();
        idle_gap(1);
        wait (pending_units.size() == 0);
        test_random(40, 1'b0);
    endtask

    // Compare every strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        unit_quat_t exp_u;
        if (i_rst_n && o_valid) begin
            if (pending_units.size() == 0) begin
                $error("unexpected result beat");
                n_fail++;
            end else begin
                exp_u = pending_units.pop_front();
                if (o_prod_w !== exp_u.unit[CW]) begin
                    $error("prod_w exp %0d got %0d", exp_u.unit[CW], o_prod_w); n_fail++;
                end
                if (o_prod_x !== exp_u.unit[CX]) begin
                    $error("prod_x exp %0d got %0d", exp_u.unit[CX], o_prod_x); n_fail++;
                end
                if (o_prod_y !== exp_u.unit[CY]) begin
                    $error("prod_y exp %0d got %0d", exp_u.unit[CY], o_prod_y); n_fail++;
                end
                if (o_prod_z !== exp_u.unit[CZ]) begin
                    $error("prod_z exp %0d got %0d", exp_u.unit[CZ], o_prod_z); n_fail++;
                end
                if (o_zero_norm !== exp_u.zero) begin
                    $error("zero_norm exp %0b got %0b", exp_u.zero, o_zero_norm); n_fail++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(900, 1'b1);
        test_drain_pause();
        test_random(800, 1'b1);
        test_random(200, 1'b0);   // closing stretch, no gaps
        idle_gap(1);
        wait (pending_units.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_fail == 0) $display("tb_top passed");
        else             $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
